// ===== rtl/wmcd_pkg.sv =====
`default_nettype none
package wmcd_pkg;

  // limits of the display geometry and of one burst of results
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned MAX_BURST   = 64;

  // field and register widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned CCOUNT_W = 13;
  localparam int unsigned HALF_W   = 12;
  localparam int unsigned REM_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // divider: dividend is column index times frame count
  localparam int unsigned DIV_W     = CCOUNT_W + FRAME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // burst counter holds 0 .. MAX_BURST
  localparam int unsigned BURST_W = $clog2(MAX_BURST + 1);

  // row scaling: extreme * half_height / 40960, 40960 = 8192 * 5
  localparam int unsigned PROD_W       = SAMPLE_W + HALF_W + 1;
  localparam int unsigned ROW_SHIFT    = 13;
  localparam int unsigned RECIP_SHIFT  = 18;
  localparam logic [15:0] RECIP_FIVE   = 16'd52429;
  localparam int unsigned ROW_MAX      = 4095;

  // empty running extremes
  localparam logic signed [SAMPLE_W-1:0] EMPTY_MIN = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] EMPTY_MAX = 16'sh8000;

  // reset values of the configuration registers
  localparam logic [FRAME_W-1:0]  RST_VIEW_FRAMES  = 32'd640;
  localparam logic [CCOUNT_W-1:0] RST_COLUMN_COUNT = 13'd640;
  localparam logic [HALF_W-1:0]   RST_HALF_HEIGHT  = 12'd240;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_FRAMES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
    logic             last;
    logic             overflow;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic div_go;
    logic div_sel_next;
    logic load_step;
    logic mul_next;
    logic load_next;
    logic begin_item;
    logic row_mul;
    logic row_div;
    logic close_col;
    logic emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dirty;
    logic restart;
    logic skip;
    logic close_due;
    logic burst_full;
    logic last_col;
    logic div_done;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/wmcd_div.sv =====
`default_nettype none
module wmcd_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [wmcd_pkg::DIV_W-1:0]          dividend_i,
  input  wire logic [wmcd_pkg::CCOUNT_W-1:0]       divisor_i,
  output logic                                     done_o,
  output logic [wmcd_pkg::DIV_W-1:0]               quot_o,
  output logic [wmcd_pkg::REM_W-1:0]               rem_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [wmcd_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [wmcd_pkg::DIV_W-1:0]        acc_q, acc_d;
  logic [wmcd_pkg::REM_W-1:0]        rem_q, rem_d;
  logic [wmcd_pkg::CCOUNT_W-1:0]     dsr_q, dsr_d;
  logic [wmcd_pkg::CCOUNT_W-1:0]     trial;
  logic                              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, acc_q[wmcd_pkg::DIV_W-1]};
    ge     = trial >= dsr_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = wmcd_pkg::DIV_CNT_W'(wmcd_pkg::DIV_W - 1);
      acc_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = {acc_q[wmcd_pkg::DIV_W-2:0], ge};
      rem_d = ge ? wmcd_pkg::REM_W'(trial - dsr_q) : trial[wmcd_pkg::REM_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/wmcd_ctrl.sv =====
`default_nettype none
module wmcd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire wmcd_pkg::status_t status_i,
  output wmcd_pkg::cmd_t         cmd_o,
  output logic                   in_stall_o
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_DIV_A   = 12'b0000_0000_0010,
    ST_WAIT_A  = 12'b0000_0000_0100,
    ST_MUL     = 12'b0000_0000_1000,
    ST_DIV_B   = 12'b0000_0001_0000,
    ST_WAIT_B  = 12'b0000_0010_0000,
    ST_BEGIN   = 12'b0000_0100_0000,
    ST_CHECK   = 12'b0000_1000_0000,
    ST_ROW_MUL = 12'b0001_0000_0000,
    ST_ROW_DIV = 12'b0010_0000_0000,
    ST_CLOSE   = 12'b0100_0000_0000,
    ST_FINISH  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   close_ok;

  // a column may close once the finished result has somewhere to go
  assign close_ok = status_i.burst_full || !status_i.pend_valid || status_i.out_free;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = status_i.dirty ? ST_DIV_A : ST_BEGIN;
        end
      end
      ST_DIV_A: begin
        cmd_o.div_go = 1'b1;
        state_d = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (status_i.div_done) begin
          cmd_o.load_step = 1'b1;
          state_d = status_i.restart ? ST_BEGIN : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_next = 1'b1;
        state_d = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd_o.div_go       = 1'b1;
        cmd_o.div_sel_next = 1'b1;
        state_d = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (status_i.div_done) begin
          cmd_o.load_next = 1'b1;
          state_d = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        cmd_o.begin_item = 1'b1;
        state_d = status_i.skip ? ST_IDLE : ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.close_due) begin
          state_d = ST_FINISH;
        end else if (status_i.burst_full) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_ROW_MUL;
        end
      end
      ST_ROW_MUL: begin
        cmd_o.row_mul = 1'b1;
        state_d = ST_ROW_DIV;
      end
      ST_ROW_DIV: begin
        cmd_o.row_div = 1'b1;
        state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (close_ok) begin
          cmd_o.close_col = 1'b1;
          state_d = status_i.last_col ? ST_FINISH : ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!status_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/wmcd_dpath.sv =====
`default_nettype none
module wmcd_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wmcd_pkg::in_word_t                  in_word_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [wmcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [wmcd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire wmcd_pkg::cmd_t                      cmd_i,
  output wmcd_pkg::status_t                        status_o,
  output logic                                     out_valid_o,
  output wmcd_pkg::out_word_t                      out_word_o,
  input  wire logic                                out_stall_i
);

  // configuration
  logic [wmcd_pkg::FRAME_W-1:0]  view_frames_q;
  logic [wmcd_pkg::CCOUNT_W-1:0] column_count_q;
  logic [wmcd_pkg::HALF_W-1:0]   half_height_q;
  logic                          dirty_q;
  logic [wmcd_pkg::FRAME_W-1:0]  n_eff;
  logic [wmcd_pkg::CCOUNT_W-1:0] w_eff;

  // frames per column, quotient and remainder
  logic [wmcd_pkg::FRAME_W-1:0]  step_quot_q;
  logic [wmcd_pkg::REM_W-1:0]    step_rem_q;

  // column walk
  logic [wmcd_pkg::COL_W-1:0]    column_pos_q;
  logic [wmcd_pkg::FRAME_W-1:0]  sample_pos_q;
  logic [wmcd_pkg::FRAME_W-1:0]  column_end_q;
  logic [wmcd_pkg::FRAME_W-1:0]  next_bound_q;
  logic [wmcd_pkg::REM_W-1:0]    end_remainder_q;
  logic signed [wmcd_pkg::SAMPLE_W-1:0] running_min_q;
  logic signed [wmcd_pkg::SAMPLE_W-1:0] running_max_q;
  logic                          pass_done_q;

  // current word
  logic signed [wmcd_pkg::SAMPLE_W-1:0] sample_q;
  logic                          first_q;
  logic [wmcd_pkg::FRAME_W-1:0]  here_q;

  // row arithmetic
  logic [wmcd_pkg::DIV_W-1:0]    prod_q;
  logic signed [wmcd_pkg::PROD_W-1:0] prod_max_q;
  logic signed [wmcd_pkg::PROD_W-1:0] prod_min_q;
  logic [wmcd_pkg::ROW_W-1:0]    top_q;
  logic [wmcd_pkg::ROW_W-1:0]    bot_q;

  // pending result and output register
  wmcd_pkg::out_word_t           pend_q;
  logic                          pend_valid_q;
  logic [wmcd_pkg::BURST_W-1:0]  burst_cnt_q;
  logic                          over_q;
  wmcd_pkg::out_word_t           out_word_q;
  logic                          out_valid_q;

  // divider
  logic [wmcd_pkg::DIV_W-1:0]    div_dividend;
  logic                          div_done;
  logic [wmcd_pkg::DIV_W-1:0]    div_quot;
  logic [wmcd_pkg::REM_W-1:0]    div_rem;

  // combinational helpers
  logic                          restart;
  logic                          skip;
  logic                          last_col;
  logic                          burst_full;
  logic                          out_free;
  logic                          push_mid;
  logic [wmcd_pkg::CCOUNT_W-1:0] col_next;
  logic [wmcd_pkg::CCOUNT_W-1:0] rsum;
  logic                          carry;
  logic [wmcd_pkg::REM_W-1:0]    rem_new;
  logic [wmcd_pkg::FRAME_W-1:0]  bound_new;
  logic [wmcd_pkg::FRAME_W-1:0]  end_new;
  logic                          fold_new;
  logic [wmcd_pkg::FRAME_W-1:0]  start_pos;
  logic signed [wmcd_pkg::SAMPLE_W-1:0] min_fold;
  logic signed [wmcd_pkg::SAMPLE_W-1:0] max_fold;

  // pixel row of one extreme: half_height minus product / 40960, toward zero, clamped to 0 .. 4095
  function automatic logic [wmcd_pkg::ROW_W-1:0] row_of(
    input logic signed [wmcd_pkg::PROD_W-1:0] p,
    input logic [wmcd_pkg::HALF_W-1:0]        h
  );
    logic [wmcd_pkg::PROD_W-1:0] mag;
    logic [14:0]                 a;
    logic [30:0]                 scaled;
    logic [12:0]                 q;
    logic signed [14:0]          r;
    mag    = p[wmcd_pkg::PROD_W-1] ? wmcd_pkg::PROD_W'(~p + 1'b1) : p;
    a      = 15'(mag >> wmcd_pkg::ROW_SHIFT);
    scaled = 31'(a) * 31'(wmcd_pkg::RECIP_FIVE);
    q      = 13'(scaled >> wmcd_pkg::RECIP_SHIFT);
    if (p[wmcd_pkg::PROD_W-1]) begin
      r = $signed({3'b000, h}) + $signed({2'b00, q});
    end else begin
      r = $signed({3'b000, h}) - $signed({2'b00, q});
    end
    if (r < 0) begin
      row_of = '0;
    end else if (r > 15'(wmcd_pkg::ROW_MAX)) begin
      row_of = wmcd_pkg::ROW_W'(wmcd_pkg::ROW_MAX);
    end else begin
      row_of = r[wmcd_pkg::ROW_W-1:0];
    end
  endfunction

  // effective frame and column counts
  assign n_eff = (view_frames_q < 32'd2) ? 32'd2 : view_frames_q;
  always_comb begin
    if (column_count_q == '0) begin
      w_eff = 13'd1;
    end else if (column_count_q > wmcd_pkg::CCOUNT_W'(wmcd_pkg::MAX_COLUMNS)) begin
      w_eff = wmcd_pkg::CCOUNT_W'(wmcd_pkg::MAX_COLUMNS);
    end else begin
      w_eff = column_count_q;
    end
  end

  // pass status
  assign restart    = first_q || ((sample_pos_q == '0) && (column_pos_q == '0) && !pass_done_q);
  assign skip       = !restart && pass_done_q;
  assign col_next   = {1'b0, column_pos_q} + 13'd1;
  assign last_col   = col_next >= w_eff;
  assign burst_full = (burst_cnt_q == wmcd_pkg::BURST_W'(wmcd_pkg::MAX_BURST));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign push_mid   = cmd_i.close_col && !burst_full && pend_valid_q;

  // next column boundary by exact stepping
  assign rsum      = {1'b0, end_remainder_q} + {1'b0, step_rem_q};
  assign carry     = rsum >= w_eff;
  assign rem_new   = carry ? wmcd_pkg::REM_W'(rsum - w_eff) : rsum[wmcd_pkg::REM_W-1:0];
  assign bound_new = next_bound_q + step_quot_q + {31'b0, carry};
  assign end_new   = (bound_new > next_bound_q) ? bound_new : (next_bound_q + 32'd1);
  assign fold_new  = next_bound_q <= here_q;

  // first sample of the word's fold
  assign start_pos = restart ? '0 : sample_pos_q;
  assign min_fold  = (restart || (sample_q < running_min_q)) ? sample_q : running_min_q;
  assign max_fold  = (restart || (sample_q > running_max_q)) ? sample_q : running_max_q;

  // shared divider: frames per column, or a fresh boundary
  assign div_dividend = cmd_i.div_sel_next ? prod_q : {13'b0, n_eff};

  wmcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (w_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_frames_q  <= wmcd_pkg::RST_VIEW_FRAMES;
      column_count_q <= wmcd_pkg::RST_COLUMN_COUNT;
      half_height_q  <= wmcd_pkg::RST_HALF_HEIGHT;
      dirty_q        <= 1'b1;
    end else begin
      if (cmd_i.load_step) begin
        dirty_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          wmcd_pkg::CFG_VIEW_FRAMES: begin
            view_frames_q <= cfg_data_i;
            dirty_q       <= 1'b1;
          end
          wmcd_pkg::CFG_COLUMN_COUNT: begin
            column_count_q <= cfg_data_i[wmcd_pkg::CCOUNT_W-1:0];
            dirty_q        <= 1'b1;
          end
          wmcd_pkg::CFG_HALF_HEIGHT: begin
            half_height_q <= cfg_data_i[wmcd_pkg::HALF_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // column walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_pos_q    <= '0;
      sample_pos_q    <= '0;
      column_end_q    <= '0;
      next_bound_q    <= '0;
      end_remainder_q <= '0;
      running_min_q   <= wmcd_pkg::EMPTY_MIN;
      running_max_q   <= wmcd_pkg::EMPTY_MAX;
      pass_done_q     <= 1'b0;
      pend_valid_q    <= 1'b0;
      burst_cnt_q     <= '0;
      over_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.load_next) begin
        next_bound_q    <= div_quot[wmcd_pkg::FRAME_W-1:0];
        end_remainder_q <= div_rem;
      end
      if (cmd_i.begin_item && !skip) begin
        sample_pos_q  <= start_pos + 32'd1;
        running_min_q <= min_fold;
        running_max_q <= max_fold;
        burst_cnt_q   <= '0;
        over_q        <= 1'b0;
        pend_valid_q  <= 1'b0;
        if (restart) begin
          column_pos_q    <= '0;
          pass_done_q     <= 1'b0;
          column_end_q    <= (step_quot_q != '0) ? step_quot_q : 32'd1;
          next_bound_q    <= step_quot_q;
          end_remainder_q <= step_rem_q;
        end
      end
      // close the column and enter the next one, or end the pass on the last column
      if (cmd_i.close_col) begin
        if (burst_full) begin
          over_q <= 1'b1;
        end else begin
          pend_valid_q <= 1'b1;
          burst_cnt_q  <= burst_cnt_q + 1'b1;
        end
        if (last_col) begin
          pass_done_q   <= 1'b1;
          running_min_q <= wmcd_pkg::EMPTY_MIN;
          running_max_q <= wmcd_pkg::EMPTY_MAX;
        end else begin
          column_pos_q    <= col_next[wmcd_pkg::COL_W-1:0];
          column_end_q    <= end_new;
          next_bound_q    <= bound_new;
          end_remainder_q <= rem_new;
          running_min_q   <= fold_new ? sample_q : wmcd_pkg::EMPTY_MIN;
          running_max_q   <= fold_new ? sample_q : wmcd_pkg::EMPTY_MAX;
        end
      end
      if (cmd_i.emit_last) begin
        pend_valid_q <= 1'b0;
      end
      // output register
      if (push_mid || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      sample_q <= in_word_i.sample;
      first_q  <= in_word_i.first;
    end
    if (cmd_i.load_step) begin
      step_quot_q <= div_quot[wmcd_pkg::FRAME_W-1:0];
      step_rem_q  <= div_rem;
    end
    if (cmd_i.mul_next) begin
      prod_q <= {32'b0, col_next} * {13'b0, n_eff};
    end
    if (cmd_i.begin_item) begin
      here_q <= start_pos;
    end
    if (cmd_i.row_mul) begin
      prod_max_q <= running_max_q * $signed({1'b0, half_height_q});
      prod_min_q <= running_min_q * $signed({1'b0, half_height_q});
    end
    if (cmd_i.row_div) begin
      top_q <= row_of(prod_max_q, half_height_q);
      bot_q <= row_of(prod_min_q, half_height_q);
    end
    if (cmd_i.close_col && !burst_full) begin
      pend_q.column     <= column_pos_q;
      pend_q.top_row    <= top_q;
      pend_q.bottom_row <= bot_q;
      pend_q.last       <= 1'b0;
      pend_q.overflow   <= 1'b0;
    end
    if (push_mid) begin
      out_word_q <= pend_q;
    end else if (cmd_i.emit_last) begin
      // closing word of the sample carries last and the overflow flag
      out_word_q <= {pend_q.column, pend_q.top_row, pend_q.bottom_row, 1'b1, over_q};
    end
  end

  // status to the controller
  always_comb begin
    status_o            = '0;
    status_o.dirty      = dirty_q;
    status_o.restart    = restart;
    status_o.skip       = skip;
    status_o.close_due  = {1'b0, column_end_q} <= ({1'b0, here_q} + 33'd1);
    status_o.burst_full = burst_full;
    status_o.last_col   = last_col;
    status_o.div_done   = div_done;
    status_o.out_free   = out_free;
    status_o.pend_valid = pend_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// ===== rtl/waveform_minmax_column_decimator.sv =====
`default_nettype none
// Min/max peak decimator for a waveform view. Samples of the visible window
// stream in, one word each, and every display column that ends on a sample
// gives one word with its top and bottom pixel rows; the last word of a sample
// carries last, and overflow when more than 64 columns fell on it. A sample
// that closes no column passes accept, fold, boundary check and finish; each
// column it closes adds check, product, scale and close, and each column
// dropped past the burst limit adds check and close. The first sample after
// a write to view_frames or column_count waits while the 45-step bit-serial
// divider finds frames per column; when that sample does not restart the
// pass, a second division finds the boundary of the next column. A stalled
// output holds the closing column in place.
module waveform_minmax_column_decimator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire wmcd_pkg::in_word_t              in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output wmcd_pkg::out_word_t                  out_word_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [wmcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wmcd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  wmcd_pkg::cmd_t    cmd;
  wmcd_pkg::status_t status;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  wmcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  wmcd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  // a taken word blocks the input until its columns are done
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // a result only moves into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_last || (cmd.close_col && !status.burst_full && status.pend_valid))
      |-> status.out_free)
    else $error("result pushed into a full output register");

  // overflow is only flagged on the closing word of a sample
  a_overflow_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.overflow) |-> out_word_o.last)
    else $error("overflow on a word that is not last");

endmodule
`default_nettype wire
